// ----- rtl/hcbd_pkg.sv -----
// ----------------------------------------------------------------------------
// hcbd_pkg: shared types and constants of the chunked body decoder
// Item and result records, framing characters and status codes.
// ----------------------------------------------------------------------------
package hcbd_pkg;

	// Width of the chunk size accumulator and of the data byte counter.
	localparam int SIZE_BITS = 32;

	localparam logic [7:0] CH_CR = 8'h0d;
	localparam logic [7:0] CH_LF = 8'h0a;

	// Result status codes.
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_ZERO     = 2'd1;
	localparam logic [1:0] ST_TRUNC    = 2'd2;
	localparam logic [1:0] ST_OVERFLOW = 2'd3;

	typedef struct packed {
		logic [7:0] body_byte;
		logic       end_of_input;
	} item_t;

	typedef struct packed {
		logic       data_valid;
		logic [7:0] out_byte;
		logic       body_end;
		logic [1:0] status;
	} result_t;

endpackage

// ----- rtl/hcbd_decoder.sv -----
// ----------------------------------------------------------------------------
// hcbd_decoder: chunk framing state machine
// Holds the decode state and works out the result of one body byte.
// ----------------------------------------------------------------------------
module hcbd_decoder import hcbd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    enable,
	input  logic    advance,
	input  item_t   item,
	output logic    res_valid,
	output result_t res
);

	typedef enum logic [2:0] {
		PH_START  = 3'd0,
		PH_DROP   = 3'd1,
		PH_DIGITS = 3'd2,
		PH_SKIP   = 3'd3,
		PH_DATA   = 3'd4,
		PH_DONE   = 3'd5
	} phase_t;

	phase_t               phase_q, phase_n;
	logic [SIZE_BITS-1:0] acc_q, acc_n, acc_cur;
	logic [SIZE_BITS-1:0] left_q, left_n, left_dec;
	logic                 digit_q, digit_n, digit_cur;
	logic                 saw_cr_q, saw_cr_n;

	logic       is_cr, is_lf, hex_ok, do_digit, valid, ended;
	logic [3:0] hex_val;
	logic [1:0] st;

	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= "0" && c <= "9") begin
			r = {1'b1, 4'(c - "0")};
		end else if (c >= "a" && c <= "f") begin
			r = {1'b1, 4'(c - "a" + 8'd10)};
		end else if (c >= "A" && c <= "F") begin
			r = {1'b1, 4'(c - "A" + 8'd10)};
		end
		return r;
	endfunction

	assign is_cr             = (item.body_byte == CH_CR);
	assign is_lf             = (item.body_byte == CH_LF);
	assign {hex_ok, hex_val} = hex_decode(item.body_byte);
	assign left_dec          = left_q - SIZE_BITS'(1);

	// A new size line starts from a cleared accumulator.
	assign acc_cur   = (phase_q == PH_START) ? '0 : acc_q;
	assign digit_cur = (phase_q == PH_START) ? 1'b0 : digit_q;

	always_comb begin
		phase_n  = phase_q;
		acc_n    = acc_q;
		left_n   = left_q;
		digit_n  = digit_q;
		saw_cr_n = saw_cr_q;
		valid    = 1'b0;
		ended    = 1'b0;
		st       = ST_OK;
		do_digit = 1'b0;

		if (!enable) begin
			valid = 1'b1;
			ended = item.end_of_input;
		end else begin
			unique case (phase_q)
				PH_START: begin
					acc_n   = '0;
					digit_n = 1'b0;
					if (is_cr) begin
						phase_n = PH_DROP;
					end else begin
						do_digit = 1'b1;
					end
				end
				PH_DROP: begin
					phase_n = PH_DIGITS;
				end
				PH_DIGITS: begin
					do_digit = 1'b1;
				end
				PH_SKIP: begin
					if (saw_cr_q && is_lf) begin
						left_n   = acc_q;
						acc_n    = '0;
						saw_cr_n = 1'b0;
						phase_n  = PH_DATA;
					end else begin
						saw_cr_n = is_cr;
					end
				end
				PH_DATA: begin
					valid = 1'b1;
					if (left_q != '0) begin
						left_n = left_dec;
					end
					if (left_q == '0 || left_dec == '0) begin
						phase_n = PH_START;
					end
				end
				PH_DONE: begin
				end
				default: begin
					phase_n = PH_START;
				end
			endcase

			if (do_digit) begin
				phase_n = PH_DIGITS;
				if (hex_ok) begin
					if (acc_cur[SIZE_BITS-1 -: 4] != 4'd0) begin
						ended   = 1'b1;
						st      = ST_OVERFLOW;
						phase_n = PH_DONE;
					end else begin
						acc_n   = {acc_cur[SIZE_BITS-5:0], hex_val};
						digit_n = 1'b1;
					end
				end else if (!digit_cur || acc_cur == '0) begin
					ended   = 1'b1;
					st      = ST_ZERO;
					phase_n = PH_DONE;
				end else begin
					saw_cr_n = is_cr;
					phase_n  = PH_SKIP;
				end
			end

			// A body that is already finished reports nothing more, not even
			// an early end of input.
			if (item.end_of_input && !ended && phase_q != PH_DONE) begin
				ended = 1'b1;
				st    = ST_TRUNC;
			end
		end

		// The last byte of a body always leaves the decoder ready for the next.
		if (item.end_of_input) begin
			phase_n  = PH_START;
			acc_n    = '0;
			left_n   = '0;
			digit_n  = 1'b0;
			saw_cr_n = 1'b0;
		end
	end

	assign res_valid      = valid || ended;
	assign res.data_valid = valid;
	assign res.out_byte   = valid ? item.body_byte : 8'd0;
	assign res.body_end   = ended;
	assign res.status     = ended ? st : ST_OK;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_START;
			acc_q    <= '0;
			left_q   <= '0;
			digit_q  <= 1'b0;
			saw_cr_q <= 1'b0;
		end else if (advance) begin
			phase_q  <= phase_n;
			acc_q    <= acc_n;
			left_q   <= left_n;
			digit_q  <= digit_n;
			saw_cr_q <= saw_cr_n;
		end
	end

endmodule

// ----- rtl/hcbd_out_reg.sv -----
// ----------------------------------------------------------------------------
// hcbd_out_reg: result register
// Holds one result until the downstream side takes the transfer.
// ----------------------------------------------------------------------------
module hcbd_out_reg import hcbd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  logic    load_valid,
	input  result_t load_data,
	input  logic    stall,
	output logic    ready,
	output logic    valid,
	output result_t data
);

	logic    valid_q;
	result_t data_q;

	// The register can take a new result when empty or when its transfer completes.
	assign ready = !valid_q || !stall;
	assign valid = valid_q;
	assign data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready) begin
			valid_q <= load && load_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && load && load_valid) begin
			data_q <= load_data;
		end
	end

endmodule

// ----- rtl/http_chunked_body_decoder_top.sv -----
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_top: HTTP chunked body decoder
// Strips chunked transfer framing from a byte stream of HTTP body data.
// ----------------------------------------------------------------------------
// The decoder takes one body byte per clock cycle while the result channel
// does not stall, and returns at most one result per byte; each byte passes
// through the input register and then the result register. That rate is set by
// the decode state logic, which is combinational so the next byte can follow
// at once. Bytes that carry framing (size lines, extensions, CR LF) or that
// come after a finished body give no result. A result carries a data byte,
// an end-of-body flag, or both; status is ok, zero chunk reached, input ended
// early, or size overflow, and is ok whenever body_end is low. After a byte
// marked end_of_input the decoder starts over for a new body. With
// chunked_enable low every byte passes through unchanged. The enable register
// should only be written while no byte is in flight.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder_top import hcbd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,

	// Configuration write channel: chunked_enable.
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_data,

	// Body byte channel.
	input  logic       body_valid,
	output logic       body_stall,
	input  logic [7:0] body_byte,
	input  logic       end_of_input,

	// Result channel.
	output logic       result_valid,
	input  logic       result_stall,
	output logic       data_valid,
	output logic [7:0] out_byte,
	output logic       body_end,
	output logic [1:0] status
);

	logic    enable_q;
	logic    valid_s1;
	item_t   item_s1;
	logic    advance;
	logic    out_ready;
	logic    dec_valid;
	result_t dec_res;
	result_t out_res;

	// The register write is always taken in the cycle it is offered.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			enable_q <= cfg_data;
		end
	end

	// The byte in the input register is decoded in the cycle that the result
	// register can take its outcome. A byte with no result still needs that
	// slot, which keeps the order of results plain.
	assign advance    = valid_s1 && out_ready;
	assign body_stall = valid_s1 && !out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!body_stall) begin
			valid_s1 <= body_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (body_valid && !body_stall) begin
			item_s1.body_byte    <= body_byte;
			item_s1.end_of_input <= end_of_input;
		end
	end

	hcbd_decoder u_decoder (
		.clk       (clk),
		.arst_n    (arst_n),
		.enable    (enable_q),
		.advance   (advance),
		.item      (item_s1),
		.res_valid (dec_valid),
		.res       (dec_res)
	);

	hcbd_out_reg u_out_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (advance),
		.load_valid (dec_valid),
		.load_data  (dec_res),
		.stall      (result_stall),
		.ready      (out_ready),
		.valid      (result_valid),
		.data       (out_res)
	);

	assign data_valid = out_res.data_valid;
	assign out_byte   = out_res.out_byte;
	assign body_end   = out_res.body_end;
	assign status     = out_res.status;

	// A result always carries a data byte or the end of the body.
	a_result_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (data_valid || body_end))
		else $error("result without data or end of body");

	// Status is only meaningful at the end of the body.
	a_status_ok_mid_body: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !body_end) |-> (status == ST_OK))
		else $error("status set on a result that does not end the body");

	// No data byte means a zero byte field.
	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !data_valid) |-> (out_byte == 8'd0))
		else $error("out_byte nonzero without data");

	// Upstream is held back only by a full result register facing a stall.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		body_stall |-> (result_valid && result_stall))
		else $error("body channel stalled without downstream stall");

endmodule

// ----- sim/tb_http_chunked_body_decoder_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_http_chunked_body_decoder_top: self-checking bench of the chunked decoder
// Feeds chunked HTTP bodies, broken bodies and noise through the decoder, with
// the framing enable switched between bodies and in the middle of one, and
// compares every result transfer with a behavioral decoder kept in the bench.
// ----------------------------------------------------------------------------
module tb_http_chunked_body_decoder_top;
	import hcbd_pkg::*;

	// Run length and pacing.
	localparam int ITEM_TARGET   = 1550;
	localparam int QUIET_SPAN    = 200;
	localparam int HOLD_AT       = 500;
	localparam int LONG_HOLD     = 300;
	localparam int SETTLE_CYCLES = 4;
	localparam int PRINT_CAP     = 40;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int DIRECTED_ROWS = 30;

	localparam result_t NO_RESULT = '0;

	// Decode phases of the size line, chunk data and finished body.
	typedef enum logic [2:0] {
		LINE_START,
		CRLF_DROP,
		SIZE_DIGITS,
		EXT_SKIP,
		CHUNK_DATA,
		BODY_DONE
	} dec_phase_t;

	// One row of the directed part: either an enable write or a body byte.
	// Rows with typed set carry their own expected result; the rest rely on
	// the bench decoder.
	typedef struct {
		bit         is_cfg;
		logic [7:0] b;
		logic       eoi;
		bit         typed;
		bit         t_has;
		result_t    t_res;
	} stim_row_t;

	logic       clk          = 1'b0;
	logic       arst_n       = 1'b0;
	logic       cfg_valid    = 1'b0;
	logic       cfg_data     = 1'b0;
	logic       body_valid   = 1'b0;
	logic [7:0] body_byte    = 8'h00;
	logic       end_of_input = 1'b0;
	logic       result_stall = 1'b0;
	logic       cfg_ready;
	logic       body_stall;
	logic       result_valid;
	logic       data_valid;
	logic [7:0] out_byte;
	logic       body_end;
	logic [1:0] status;

	http_chunked_body_decoder_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.body_valid   (body_valid),
		.body_stall   (body_stall),
		.body_byte    (body_byte),
		.end_of_input (end_of_input),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.data_valid   (data_valid),
		.out_byte     (out_byte),
		.body_end     (body_end),
		.status       (status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Decoder state as the bench sees it, and its copy of the enable bit.
	dec_phase_t           line_phase;
	logic [SIZE_BITS-1:0] size_acc;
	logic [SIZE_BITS-1:0] data_left;
	bit                   have_digit;
	bit                   cr_pending;
	bit                   framing_on;

	// Results still owed by the decoder, oldest first.
	result_t pending_results[$];

	// Bytes of the body currently being built by the generator.
	logic [7:0] body_stream[$];

	int          mismatch_count = 0;
	int          bytes_sent     = 0;
	int unsigned cycle_count    = 0;

	// Pacing controls shared by the sender, the receiver and the main flow.
	bit quiet     = 1'b0;
	bit gap_on    = 1'b0;
	bit hold_req  = 1'b0;
	int hold_left = 0;

	// The directed part. The first two bytes go through with framing off, right
	// after reset. Then a two byte chunk with its trailing CR LF, a zero chunk
	// and a byte after the end of the body; a size line that starts with a
	// space; a size that overflows on its ninth digit together with end of
	// input; and a one byte chunk whose data byte ends the input early, with
	// framing briefly turned off in the middle of it.
	stim_row_t directed_rows [DIRECTED_ROWS] = '{
		'{1'b0, 8'h00, 1'b0, 1'b1, 1'b1, {1'b1, 8'h00, 1'b0, ST_OK}},
		'{1'b0, 8'hff, 1'b1, 1'b1, 1'b1, {1'b1, 8'hff, 1'b1, ST_OK}},
		'{1'b1, 8'h01, 1'b0, 1'b0, 1'b0, NO_RESULT},
		'{1'b0, "2",   1'b0, 1'b0, 1'b0, NO_RESULT},
		'{1'b0, CH_CR, 1'b0, 1'b0, 1'b0, NO_RESULT},
		'{1'b0, CH_LF, 1'b0, 1'b0, 1'b0, NO_RESULT},
		'{1'b0, "a",   1'b0, 1'b0, 1'b0, NO_RESULT},
		'{1'b0, "b",   1'b0, 1'b0, 1'b0, NO_RESULT},
		'{1'b0, CH_CR, 1'b0, 1'b0, 1'b0, NO_RESULT},
		'{1'b0, CH_LF, 1'b0, 1'b0, 1'b0, NO_RESULT},
		'{1'b0, "0",   1'b0, 1'b0, 1'b0, NO_RESULT},
		'{1'b0, CH_CR, 1'b0, 1'b1, 1'b1, {1'b0, 8'h00, 1'b1, ST_ZERO}},
		'{1'b0, CH_LF, 1'b1, 1'b1, 1'b0, NO_RESULT},
		'{1'b0, " ",   1'b1, 1'b1, 1'b1, {1'b0, 8'h00, 1'b1, ST_ZERO}},
		'{1'b0, "1",   1'b0, 1'b0, 1'b0, NO_RESULT},
		'{1'b0, "0",   1'b0, 1'b0, 1'b0, NO_RESULT},
		'{1'b0, "0",   1'b0, 1'b0, 1'b0, NO_RESULT},
		'{1'b0, "0",   1'b0, 1'b0, 1'b0, NO_RESULT},
		'{1'b0, "0",   1'b0, 1'b0, 1'b0, NO_RESULT},
		'{1'b0, "0",   1'b0, 1'b0, 1'b0, NO_RESULT},
		'{1'b0, "0",   1'b0, 1'b0, 1'b0, NO_RESULT},
		'{1'b0, "0",   1'b0, 1'b0, 1'b0, NO_RESULT},
		'{1'b0, "a",   1'b1, 1'b1, 1'b1, {1'b0, 8'h00, 1'b1, ST_OVERFLOW}},
		'{1'b0, "1",   1'b0, 1'b0, 1'b0, NO_RESULT},
		'{1'b0, CH_CR, 1'b0, 1'b0, 1'b0, NO_RESULT},
		'{1'b0, CH_LF, 1'b0, 1'b0, 1'b0, NO_RESULT},
		'{1'b1, 8'h00, 1'b0, 1'b0, 1'b0, NO_RESULT},
		'{1'b0, 8'h80, 1'b0, 1'b1, 1'b1, {1'b1, 8'h80, 1'b0, ST_OK}},
		'{1'b1, 8'h01, 1'b0, 1'b0, 1'b0, NO_RESULT},
		'{1'b0, "Z",   1'b1, 1'b1, 1'b1, {1'b1, "Z", 1'b1, ST_TRUNC}}
	};

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= PRINT_CAP) begin
			$display("%0t: mismatch: %s", $time, msg);
		end
	endtask

	// Every byte with end_of_input set puts the decoder back to the start of
	// a new body; the enable bit is kept.
	function automatic void restart_body();
		line_phase = LINE_START;
		size_acc   = '0;
		data_left  = '0;
		have_digit = 1'b0;
		cr_pending = 1'b0;
	endfunction

	// Bench decoder: takes one body byte, updates the decode state, and tells
	// whether the byte yields a result and what that result holds.
	function automatic bit chunk_decode(input logic [7:0] b, input logic eoi,
	                                    output result_t res);
		int         digit;
		bit         consumed;
		bit         is_data;
		bit         ended;
		logic [1:0] code;
		consumed = 1'b0;
		is_data  = 1'b0;
		ended    = 1'b0;
		code     = ST_OK;
		res      = NO_RESULT;

		// With framing off every byte is data and end of input ends the body.
		if (!framing_on) begin
			res = {1'b1, b, eoi, ST_OK};
			if (eoi) restart_body();
			return 1'b1;
		end

		if (line_phase == BODY_DONE) begin
			if (eoi) restart_body();
			return 1'b0;
		end

		// A CR at the start of a size line is the tail of the previous chunk;
		// it and the byte after it are dropped.
		if (line_phase == LINE_START) begin
			have_digit = 1'b0;
			size_acc   = '0;
			if (b == CH_CR) begin
				line_phase = CRLF_DROP;
				consumed   = 1'b1;
			end else begin
				line_phase = SIZE_DIGITS;
			end
		end else if (line_phase == CRLF_DROP) begin
			line_phase = SIZE_DIGITS;
			consumed   = 1'b1;
		end

		if (line_phase == SIZE_DIGITS && !consumed) begin
			if (b >= "0" && b <= "9") begin
				digit = b - "0";
			end else if (b >= "a" && b <= "f") begin
				digit = b - "a" + 10;
			end else if (b >= "A" && b <= "F") begin
				digit = b - "A" + 10;
			end else begin
				digit = -1;
			end
			if (digit >= 0) begin
				// One more digit would push the size out of the accumulator.
				if (size_acc[SIZE_BITS-1 -: 4] != 4'd0) begin
					ended      = 1'b1;
					code       = ST_OVERFLOW;
					line_phase = BODY_DONE;
				end else begin
					size_acc   = (size_acc << 4) | SIZE_BITS'(digit);
					have_digit = 1'b1;
				end
			end else if (!have_digit || size_acc == '0) begin
				ended      = 1'b1;
				code       = ST_ZERO;
				line_phase = BODY_DONE;
			end else begin
				cr_pending = (b == CH_CR);
				line_phase = EXT_SKIP;
			end
		end else if (line_phase == EXT_SKIP) begin
			if (cr_pending && b == CH_LF) begin
				data_left  = size_acc;
				size_acc   = '0;
				cr_pending = 1'b0;
				line_phase = CHUNK_DATA;
			end else begin
				cr_pending = (b == CH_CR);
			end
		end else if (line_phase == CHUNK_DATA) begin
			is_data = 1'b1;
			if (data_left != '0) data_left = data_left - 1'b1;
			if (data_left == '0) line_phase = LINE_START;
		end

		if (eoi && !ended) begin
			ended = 1'b1;
			code  = ST_TRUNC;
		end
		if (eoi) restart_body();

		if (!is_data && !ended) return 1'b0;
		res = {is_data, is_data ? b : 8'h00, ended, code};
		return 1'b1;
	endfunction

	// Appends a size line in hex with random letter case, now and then a
	// leading zero or a chunk extension, closed by CR LF.
	function automatic void add_size_line(input logic [39:0] value);
		int         top;
		logic [3:0] nib;
		top = 0;
		for (int k = 9; k > 0; k--) begin
			if (top == 0 && value[4*k +: 4] != 4'd0) top = k;
		end
		if ($urandom_range(0, 3) == 0) body_stream.push_back("0");
		for (int k = top; k >= 0; k--) begin
			nib = value[4*k +: 4];
			if (nib < 4'd10) begin
				body_stream.push_back("0" + nib);
			end else begin
				body_stream.push_back(($urandom_range(0, 1) ? "a" : "A") + nib - 8'd10);
			end
		end
		if ($urandom_range(0, 3) == 0) begin
			body_stream.push_back(";");
			repeat ($urandom_range(0, 4)) body_stream.push_back(8'($urandom_range(32, 126)));
		end
		body_stream.push_back(CH_CR);
		body_stream.push_back(CH_LF);
	endfunction

	// Builds one body. Most are well formed with random chunk data; some are
	// cut short, have one byte replaced, end on an oversized chunk size, or are
	// plain noise.
	function automatic void build_body();
		int kind;
		int chunk_len;
		int cut;
		body_stream.delete();
		kind = $urandom_range(0, 99);
		if (kind >= 92) begin
			repeat ($urandom_range(1, 20)) body_stream.push_back(8'($urandom));
			return;
		end
		repeat ($urandom_range(0, 3)) begin
			chunk_len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 64)
			                                        : $urandom_range(1, 8);
			add_size_line(40'(chunk_len));
			repeat (chunk_len) body_stream.push_back(8'($urandom));
			body_stream.push_back(CH_CR);
			body_stream.push_back(CH_LF);
		end
		if (kind >= 84) begin
			add_size_line({4'($urandom_range(1, 15)), 32'($urandom)});
		end else begin
			add_size_line(40'd0);
			body_stream.push_back(CH_CR);
			body_stream.push_back(CH_LF);
		end
		repeat ($urandom_range(0, 3)) body_stream.push_back(8'($urandom));
		if (kind >= 60 && kind < 74) begin
			cut = $urandom_range(1, body_stream.size());
			while (body_stream.size() > cut) void'(body_stream.pop_back());
		end else if (kind >= 74 && kind < 84) begin
			body_stream[$urandom_range(0, body_stream.size() - 1)] = 8'($urandom);
		end
	endfunction

	// Offers one byte and waits for its transfer. Valid stays high afterwards
	// so that back-to-back bytes need no second assignment in one time step.
	task automatic send_byte(input logic [7:0] b, input logic eoi, input bit typed,
	                         input bit t_has, input result_t t_res);
		result_t res;
		bit      has;
		if (gap_on && !quiet && $urandom_range(0, 5) == 0) begin
			body_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		body_valid   <= 1'b1;
		body_byte    <= b;
		end_of_input <= eoi;
		do @(posedge clk); while (body_stall);
		has = chunk_decode(b, eoi, res);
		if (typed) begin
			has = t_has;
			res = t_res;
		end
		if (has) pending_results.push_back(res);
		bytes_sent++;
	endtask

	// The enable is written only with nothing in flight: all owed results
	// have arrived and a byte that gives no result has had time to pass.
	task automatic write_enable(input logic value);
		body_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid  <= 1'b0;
		framing_on = value;
	endtask

	// Receiver: random stall bursts, calm stretches, one long hold that backs
	// the decoder up into its input, and no stalls at all in the last part.
	initial begin : result_side
		int burst_left;
		bit calm;
		burst_left = 0;
		calm       = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else if (burst_left > 0) begin
				burst_left--;
				result_stall <= 1'b1;
			end else if (quiet || calm) begin
				result_stall <= 1'b0;
			end else if ($urandom_range(0, 5) == 0) begin
				burst_left = $urandom_range(1, 12) - 1;
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
			end
			if ($urandom_range(0, 199) == 0) calm = !calm;
		end
	end

	// Each result transfer is checked field by field against the oldest
	// owed result.
	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("result transfer with none owed: dv=%b byte=%h end=%b st=%0d",
				                          data_valid, out_byte, body_end, status));
			end else begin
				want = pending_results.pop_front();
				if (data_valid !== want.data_valid)
					report_mismatch($sformatf("data_valid %b, expected %b",
					                          data_valid, want.data_valid));
				if (out_byte !== want.out_byte)
					report_mismatch($sformatf("out_byte %h, expected %h",
					                          out_byte, want.out_byte));
				if (body_end !== want.body_end)
					report_mismatch($sformatf("body_end %b, expected %b",
					                          body_end, want.body_end));
				if (status !== want.status)
					report_mismatch($sformatf("status %0d, expected %0d",
					                          status, want.status));
			end
		end
	end

	// Watchdog against a hung handshake.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin : stimulus
		int  split_at;
		bit  hold_fired;
		bit  holding;
		hold_fired = 1'b0;
		restart_body();
		framing_on = 1'b0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		gap_on = 1'b1;
		foreach (directed_rows[i]) begin
			if (directed_rows[i].is_cfg) begin
				write_enable(directed_rows[i].b[0]);
			end else begin
				send_byte(directed_rows[i].b, directed_rows[i].eoi, directed_rows[i].typed,
				          directed_rows[i].t_has, directed_rows[i].t_res);
			end
		end

		// Random bodies. Enable writes fall between bodies and, now and then,
		// in the middle of one, where decoding must pick up where it stopped.
		while (bytes_sent < ITEM_TARGET) begin
			if (!hold_fired && bytes_sent >= HOLD_AT) begin
				hold_fired = 1'b1;
				hold_req   = 1'b1;
			end
			holding = hold_req || hold_left > 0;
			quiet   = bytes_sent >= ITEM_TARGET - QUIET_SPAN;
			gap_on  = !holding && $urandom_range(0, 2) != 0;
			if (!holding && !quiet && $urandom_range(0, 4) == 0) begin
				write_enable($urandom_range(0, 3) != 0);
			end
			build_body();
			split_at = -1;
			if (!holding && !quiet && body_stream.size() > 1 && $urandom_range(0, 9) == 0) begin
				split_at = $urandom_range(1, body_stream.size() - 1);
			end
			foreach (body_stream[i]) begin
				if (i == split_at) write_enable($urandom_range(0, 1));
				send_byte(body_stream[i], i == body_stream.size() - 1, 1'b0, 1'b0, NO_RESULT);
			end
		end

		body_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (3 * SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
